@@ rtl/core/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the script text tokenizer
// Lexer modes, character codes and the result bundle passed from the
// classifying front end through the queue to the serializing back end.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

	// Lexer modes
	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_QUOTED  = 2'd1,
		MODE_HASH    = 2'd2,
		MODE_COMMENT = 2'd3
	} lex_mode_t;

	// Character codes
	localparam logic [7:0] ChSemi    = 8'h3B;
	localparam logic [7:0] ChComma   = 8'h2C;
	localparam logic [7:0] ChLParen  = 8'h28;
	localparam logic [7:0] ChRParen  = 8'h29;
	localparam logic [7:0] ChHash    = 8'h23;
	localparam logic [7:0] ChUnder   = 8'h5F;
	localparam logic [7:0] ChQuote   = 8'h22;
	localparam logic [7:0] ChNewline = 8'h0A;
	localparam logic [7:0] ChSpace   = 8'h20;
	localparam logic [7:0] ChTab     = 8'h09;
	localparam logic [7:0] ChCr      = 8'h0D;

	// Result kinds carried on tuser
	localparam logic KindByte = 1'b0;
	localparam logic KindMark = 1'b1;

	// Default depth of the queue between front and back end
	localparam int QueueDepthDefault = 4;

	// Results caused by one byte: an optional end mark, an optional token
	// byte and an optional trailing end mark, emitted in that order.
	typedef struct packed {
		logic       lead_mark;
		logic       has_byte;
		logic [7:0] tok_byte;
		logic       tail_mark;
	} stt_bundle_t;

endpackage

`default_nettype wire

@@ rtl/core/stt_front.sv @@
// ----------------------------------------------------------------------------
// stt_front: byte classifier
// Accepts one byte per cycle while the queue is not full, tracks the lexer mode and the pending token,
// and pushes the results each byte causes as one bundle into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire  [7:0]           in_char,
	input  wire                  in_eot,
	output logic                 push,
	output stt_pkg::stt_bundle_t push_bundle,
	input  wire                  queue_full
);

	stt_pkg::lex_mode_t mode_q, mode_d;
	logic               open_q, open_d;
	logic               accept;
	logic               is_delim, is_space;
	stt_pkg::stt_bundle_t bnd;
	logic               plain;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// Classify the incoming byte
	assign is_delim = (in_char == stt_pkg::ChSemi) || (in_char == stt_pkg::ChComma) ||
	                  (in_char == stt_pkg::ChLParen) || (in_char == stt_pkg::ChRParen);
	assign is_space = (in_char == stt_pkg::ChSpace) ||
	                  ((in_char >= stt_pkg::ChTab) && (in_char <= stt_pkg::ChCr));

	// Decide results and next mode
	always_comb begin
		mode_d = mode_q;
		open_d = open_q;
		bnd    = '0;
		plain  = 1'b0;
		if (in_eot) begin
			bnd.lead_mark = (mode_q != stt_pkg::MODE_COMMENT);
			mode_d        = stt_pkg::MODE_NORMAL;
			open_d        = 1'b0;
		end else begin
			unique case (mode_q)
				stt_pkg::MODE_QUOTED: begin
					if (in_char == stt_pkg::ChQuote) begin
						bnd.lead_mark = 1'b1;
						open_d        = 1'b0;
						mode_d        = stt_pkg::MODE_NORMAL;
					end else begin
						bnd.has_byte = 1'b1;
						bnd.tok_byte = (in_char == stt_pkg::ChUnder) ? stt_pkg::ChSpace : in_char;
						open_d       = 1'b1;
					end
				end
				stt_pkg::MODE_HASH: begin
					if (in_char == stt_pkg::ChHash) begin
						mode_d = stt_pkg::MODE_COMMENT;
					end else begin
						mode_d = stt_pkg::MODE_NORMAL;
						plain  = 1'b1;
					end
				end
				stt_pkg::MODE_COMMENT: begin
					if (in_char == stt_pkg::ChNewline) begin
						mode_d = stt_pkg::MODE_NORMAL;
						plain  = 1'b1;
					end
				end
				stt_pkg::MODE_NORMAL: begin
					if (in_char == stt_pkg::ChQuote) begin
						mode_d = stt_pkg::MODE_QUOTED;
					end else if (in_char == stt_pkg::ChHash) begin
						mode_d = stt_pkg::MODE_HASH;
					end else begin
						plain = 1'b1;
					end
				end
				default: begin
					mode_d = stt_pkg::MODE_NORMAL;
				end
			endcase
			// Plain byte: delimiter, separator or token byte
			if (plain) begin
				if (is_delim) begin
					bnd.lead_mark = open_q;
					bnd.has_byte  = 1'b1;
					bnd.tok_byte  = in_char;
					bnd.tail_mark = 1'b1;
					open_d        = 1'b0;
				end else if (is_space) begin
					bnd.lead_mark = open_q;
					open_d        = 1'b0;
				end else begin
					bnd.has_byte = 1'b1;
					bnd.tok_byte = in_char;
					open_d       = 1'b1;
				end
			end
		end
	end

	// Push only bundles that carry at least one result
	assign push        = accept && (bnd.lead_mark || bnd.has_byte || bnd.tail_mark);
	assign push_bundle = bnd;

	// Advance lexer state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stt_pkg::MODE_NORMAL;
			open_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			open_q <= open_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/stt_queue.sv @@
// ----------------------------------------------------------------------------
// stt_queue: bundle queue
// Small register FIFO between classifier and serializer so each side can
// stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_queue #(
	parameter int Depth = stt_pkg::QueueDepthDefault
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  stt_pkg::stt_bundle_t push_bundle,
	output logic                 full,
	input  wire                  pop,
	output stt_pkg::stt_bundle_t head,
	output logic                 empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

	stt_pkg::stt_bundle_t entries_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push, do_pop;

	assign full    = (count_q == DepthCnt);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entries_q[rd_ptr_q];

	// Write entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_bundle;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/stt_back.sv @@
// ----------------------------------------------------------------------------
// stt_back: result serializer
// Takes bundles from the queue and emits their results one per cycle, while the output is not stalled, into
// a registered output stage, marking the final result of each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  stt_pkg::stt_bundle_t head,
	input  wire                  empty,
	output logic                 pop,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [7:0]           out_byte,
	output logic                 out_kind,
	output logic                 out_last
);

	stt_pkg::stt_bundle_t cur_q, src, rem;
	logic       use_cur, src_ok, load;
	logic       kind_d;
	logic [7:0] byte_d;
	logic       valid_q, kind_q, last_q;
	logic [7:0] byte_q;

	assign use_cur = cur_q.lead_mark || cur_q.has_byte || cur_q.tail_mark;
	assign src     = use_cur ? cur_q : head;
	assign src_ok  = use_cur || !empty;
	assign load    = (!valid_q || out_ready) && src_ok;
	assign pop     = load && !use_cur;

	// Pick the first pending result of the source bundle
	always_comb begin
		rem    = src;
		kind_d = stt_pkg::KindMark;
		byte_d = '0;
		priority if (src.lead_mark) begin
			rem.lead_mark = 1'b0;
		end else if (src.has_byte) begin
			rem.has_byte = 1'b0;
			kind_d       = stt_pkg::KindByte;
			byte_d       = src.tok_byte;
		end else begin
			rem.tail_mark = 1'b0;
		end
	end

	// Hold the rest of the bundle being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (load) begin
			cur_q <= rem;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_d;
			byte_q <= byte_d;
			last_q <= !(rem.lead_mark || rem.has_byte || rem.tail_mark);
		end
	end

	assign out_valid = valid_q;
	assign out_kind  = kind_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

endmodule

`default_nettype wire

@@ rtl/core/script_text_tokenizer.sv @@
// ----------------------------------------------------------------------------
// script_text_tokenizer: byte stream tokenizer
// Splits text into tokens, emitting token bytes followed by end marks.
// ----------------------------------------------------------------------------
// Path: the first result of a byte passes a queue entry, then the output register.
// Throughput: one byte per cycle while the queue is not full; results leave at
//   one per cycle while m_tready is high; the extra results of bytes that cause
//   two or three wait in the QueueDepth-entry queue between classifier and serializer.
// Reset: arst_n clears lexer mode to normal, drops any pending token, empties
//   the queue and the output register.
`default_nettype none

module script_text_tokenizer #(
	parameter int QueueDepth = stt_pkg::QueueDepthDefault
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,   // [7:0] character
	input  wire        s_tlast,   // end_of_text
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // [7:0] token_byte
	output logic       m_tuser,   // [0] kind
	output logic       m_tlast    // last_of_run
);

	stt_pkg::stt_bundle_t push_bundle, head;
	logic push, full, pop, empty;

	// Classify incoming bytes
	stt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_char     (s_tdata),
		.in_eot      (s_tlast),
		.push        (push),
		.push_bundle (push_bundle),
		.queue_full  (full)
	);

	// Buffer result bundles
	stt_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_bundle (push_bundle),
		.full        (full),
		.pop         (pop),
		.head        (head),
		.empty       (empty)
	);

	// Serialize results onto the output stream
	stt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_kind  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

`default_nettype wire

@@ rtl/core/stt_checker.sv @@
// ----------------------------------------------------------------------------
// stt_checker: port-level checks of the tokenizer
// Watches the output for results the lexing rules cannot produce, stall holds and reset.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       s_tvalid,
	input wire       s_tready,
	input wire [7:0] s_tdata,
	input wire       s_tlast,
	input wire       m_tvalid,
	input wire       m_tready,
	input wire [7:0] m_tdata,
	input wire       m_tuser,
	input wire       m_tlast
);

	// End marks carry a zero byte
	a_mark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == stt_pkg::KindMark) |-> m_tdata == 8'h00)
		else $error("end mark with nonzero byte");

	// Only a delimiter byte is followed by more results of the same request
	a_delim_mid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == stt_pkg::KindByte) && !m_tlast |->
		(m_tdata == stt_pkg::ChSemi) || (m_tdata == stt_pkg::ChComma) ||
		(m_tdata == stt_pkg::ChLParen) || (m_tdata == stt_pkg::ChRParen))
		else $error("token byte not last of its request");

	// A stalled request holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=>
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("output request changed while stalled");

	// A stalled input request stays in place
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=>
		s_tvalid && $stable(s_tdata) && $stable(s_tlast))
		else $error("input request changed while stalled");

	// Nothing comes out right after reset before any input was taken
	a_quiet_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("output valid right after reset");

endmodule

bind script_text_tokenizer stt_checker u_stt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

@@ sim/script_text_tokenizer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// script_text_tokenizer_tb: self-checking bench for the byte stream tokenizer
// Sends text bytes and end-of-text requests. A local model of the lexer
// predicts the token bytes and end marks of each request, and every result
// is compared field by field with the oldest prediction. Runs directed cases,
// then random text under varying sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module script_text_tokenizer_tb;

	localparam int ClkHalf    = 4;
	localparam int StallLimit = 2000;
	localparam int TailCycles = 8;

	typedef struct packed {
		logic       kind;
		logic [7:0] tok_byte;
		logic       last;
	} tok_result_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;    // [7:0] character
	logic       s_tlast;    // end_of_text
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;    // [7:0] token_byte
	logic       m_tuser;    // [0] kind
	logic       m_tlast;    // last_of_run

	// Lexer model state
	stt_pkg::lex_mode_t lex_mode_q;
	logic               token_open_q;
	tok_result_t        token_results_q[$];
	tok_result_t        step_results[$];
	tok_result_t        head_r;

	int tx_idle_pct;
	int rx_stall_pct;
	int sent_cnt;
	int err_cnt;
	int quiet_cnt;

	script_text_tokenizer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #ClkHalf clk = ~clk;

	function automatic logic is_blank(input logic [7:0] c);
		return c == stt_pkg::ChSpace || (c >= stt_pkg::ChTab && c <= stt_pkg::ChCr);
	endfunction

	function automatic logic is_delim(input logic [7:0] c);
		return c == stt_pkg::ChSemi || c == stt_pkg::ChComma ||
		       c == stt_pkg::ChLParen || c == stt_pkg::ChRParen;
	endfunction

	function void emit(input logic kind, input logic [7:0] b);
		tok_result_t r;
		r.kind     = kind;
		r.tok_byte = (kind == stt_pkg::KindMark) ? 8'h00 : b;
		r.last     = 1'b0;
		step_results = {step_results, r};
	endfunction

	// Normal-mode handling, shared by normal mode, the byte after one hash and the newline
	// that closes a comment
	function void lex_plain(input logic [7:0] c);
		if (is_delim(c)) begin
			if (token_open_q)
				emit(stt_pkg::KindMark, 8'h00);
			emit(stt_pkg::KindByte, c);
			emit(stt_pkg::KindMark, 8'h00);
			token_open_q = 1'b0;
		end else if (is_blank(c)) begin
			if (token_open_q)
				emit(stt_pkg::KindMark, 8'h00);
			token_open_q = 1'b0;
		end else begin
			emit(stt_pkg::KindByte, c);
			token_open_q = 1'b1;
		end
	endfunction

	// Predict the results of one accepted request and queue them
	function void tokenize_byte(input logic [7:0] c, input logic eot);
		step_results.delete();
		if (eot) begin
			if (lex_mode_q != stt_pkg::MODE_COMMENT)
				emit(stt_pkg::KindMark, 8'h00);
			lex_mode_q   = stt_pkg::MODE_NORMAL;
			token_open_q = 1'b0;
		end else begin
			case (lex_mode_q)
				stt_pkg::MODE_QUOTED: begin
					if (c == stt_pkg::ChQuote) begin
						emit(stt_pkg::KindMark, 8'h00);
						token_open_q = 1'b0;
						lex_mode_q   = stt_pkg::MODE_NORMAL;
					end else begin
						emit(stt_pkg::KindByte,
							(c == stt_pkg::ChUnder) ? stt_pkg::ChSpace : c);
						token_open_q = 1'b1;
					end
				end
				stt_pkg::MODE_HASH: begin
					if (c == stt_pkg::ChHash) begin
						lex_mode_q = stt_pkg::MODE_COMMENT;
					end else begin
						lex_mode_q = stt_pkg::MODE_NORMAL;
						lex_plain(c);
					end
				end
				stt_pkg::MODE_COMMENT: begin
					if (c == stt_pkg::ChNewline) begin
						lex_mode_q = stt_pkg::MODE_NORMAL;
						lex_plain(c);
					end
				end
				default: begin
					if (c == stt_pkg::ChQuote)
						lex_mode_q = stt_pkg::MODE_QUOTED;
					else if (c == stt_pkg::ChHash)
						lex_mode_q = stt_pkg::MODE_HASH;
					else
						lex_plain(c);
				end
			endcase
		end
		if (step_results.size() > 0)
			step_results[step_results.size() - 1].last = 1'b1;
		token_results_q = {token_results_q, step_results};
	endfunction

	task report_mismatch(input string msg);
		$display("ERROR %0t: %s", $time, msg);
		err_cnt++;
	endtask

	// Send one request, with random idle cycles ahead of it
	task send_request(input logic [7:0] c, input logic eot);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eot;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tokenize_byte(c, eot);
		sent_cnt++;
	endtask

	// Hold the sender until every predicted result has come out
	task wait_drained();
		s_tvalid <= 1'b0;
		while (token_results_q.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_word_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (is_blank(b) || is_delim(b) || b == stt_pkg::ChQuote ||
		       b == stt_pkg::ChHash);
		return b;
	endfunction

	// Send one random piece of text: mostly well-formed, some noise
	task send_fragment();
		int         n;
		logic [7:0] b;
		case ($urandom_range(9))
			0, 1, 2: begin
				n = $urandom_range(1, 4);
				repeat (n) send_request(pick_word_byte(), 1'b0);
			end
			3: begin
				if ($urandom_range(5) == 0)
					b = stt_pkg::ChSpace;
				else
					b = stt_pkg::ChTab + 8'($urandom_range(4));
				send_request(b, 1'b0);
			end
			4: begin
				case ($urandom_range(3))
					0:       b = stt_pkg::ChSemi;
					1:       b = stt_pkg::ChComma;
					2:       b = stt_pkg::ChLParen;
					default: b = stt_pkg::ChRParen;
				endcase
				send_request(b, 1'b0);
			end
			5: begin
				send_request(stt_pkg::ChQuote, 1'b0);
				n = $urandom_range(0, 4);
				repeat (n) begin
					if ($urandom_range(2) == 0) begin
						b = stt_pkg::ChUnder;
					end else begin
						do
							b = 8'($urandom_range(255));
						while (b == stt_pkg::ChQuote);
					end
					send_request(b, 1'b0);
				end
				// leave a few quoted runs open
				if ($urandom_range(9) != 0)
					send_request(stt_pkg::ChQuote, 1'b0);
			end
			6: begin
				send_request(stt_pkg::ChHash, 1'b0);
				send_request(stt_pkg::ChHash, 1'b0);
				n = $urandom_range(0, 3);
				repeat (n) begin
					do
						b = 8'($urandom_range(255));
					while (b == stt_pkg::ChNewline);
					send_request(b, 1'b0);
				end
				send_request(stt_pkg::ChNewline, 1'b0);
			end
			7: begin
				send_request(stt_pkg::ChHash, 1'b0);
				send_request(8'($urandom_range(255)), 1'b0);
			end
			8: send_request(8'($urandom_range(255)), 1'b1);
			default: send_request(8'($urandom_range(255)), 1'b0);
		endcase
	endtask

	task run_random(input int n_items);
		int target;
		target = sent_cnt + n_items;
		while (sent_cnt < target)
			send_fragment();
	endtask

	task test_directed();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		send_request(8'h80, 1'b0);               // high byte opens a token
		send_request(stt_pkg::ChQuote, 1'b0);    // quote joins the pending token
		send_request(stt_pkg::ChUnder, 1'b0);    // underscore turns into a space
		send_request(8'h00, 1'b0);
		send_request(stt_pkg::ChQuote, 1'b0);    // closing quote ends the token
		send_request(stt_pkg::ChQuote, 1'b0);
		send_request(stt_pkg::ChQuote, 1'b0);    // empty quoted token: mark only
		send_request(8'hFF, 1'b0);
		send_request(stt_pkg::ChSemi, 1'b0);     // delimiter after open token
		send_request(stt_pkg::ChLParen, 1'b0);   // delimiter with nothing pending
		send_request(stt_pkg::ChComma, 1'b0);
		send_request(stt_pkg::ChTab, 1'b0);      // blank with nothing pending
		send_request(8'h61, 1'b0);
		send_request(stt_pkg::ChRParen, 1'b0);
		send_request(stt_pkg::ChHash, 1'b0);
		send_request(stt_pkg::ChQuote, 1'b0);    // quote after one hash is a plain byte
		send_request(stt_pkg::ChHash, 1'b0);
		send_request(stt_pkg::ChHash, 1'b0);     // double hash starts a comment
		send_request(8'h7A, 1'b0);
		send_request(stt_pkg::ChNewline, 1'b0);  // newline ends comment and token
		send_request(stt_pkg::ChHash, 1'b0);
		send_request(8'hFF, 1'b1);               // end of text after one hash
		send_request(stt_pkg::ChQuote, 1'b0);
		send_request(8'h00, 1'b1);               // end of text inside quotes
		send_request(stt_pkg::ChHash, 1'b0);
		send_request(stt_pkg::ChHash, 1'b0);
		send_request(8'h5A, 1'b1);               // end of text inside a comment
		send_request(8'h00, 1'b1);               // end of text with empty token
		wait_drained();
	endtask

	task test_no_idle();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		run_random(38);
	endtask

	task test_sender_idle();
		tx_idle_pct  = 88;
		rx_stall_pct = 0;
		run_random(38);
	endtask

	task test_receiver_stall();
		tx_idle_pct  = 0;
		rx_stall_pct = 88;
		run_random(20);
		wait_drained();
		run_random(18);
	endtask

	task test_both_idle();
		tx_idle_pct  = 28;
		rx_stall_pct = 28;
		run_random(38);
	endtask

	// Drive the receiver ready with random stalls
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= rx_stall_pct);

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (token_results_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind=%0b byte=%02h last=%0b",
					m_tuser, m_tdata, m_tlast));
			end else begin
				head_r = token_results_q.pop_front();
				if (m_tuser !== head_r.kind)
					report_mismatch($sformatf("kind %0b, predicted %0b",
						m_tuser, head_r.kind));
				if (m_tdata !== head_r.tok_byte)
					report_mismatch($sformatf("token_byte %02h, predicted %02h",
						m_tdata, head_r.tok_byte));
				if (m_tlast !== head_r.last)
					report_mismatch($sformatf("last_of_run %0b, predicted %0b",
						m_tlast, head_r.last));
			end
		end
	end

	// End the run when no request moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cnt <= 0;
			end else if (quiet_cnt >= StallLimit) begin
				$display("watchdog: no handshake for %0d cycles", quiet_cnt);
				$display("script_text_tokenizer: mismatch");
				$finish;
			end else begin
				quiet_cnt <= quiet_cnt + 1;
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = 8'h00;
		s_tlast      = 1'b0;
		m_tready     = 1'b0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		sent_cnt     = 0;
		err_cnt      = 0;
		quiet_cnt    = 0;
		lex_mode_q   = stt_pkg::MODE_NORMAL;
		token_open_q = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		wait_drained();

		if (token_results_q.size() != 0)
			report_mismatch($sformatf("%0d predicted results never came",
				token_results_q.size()));
		if (err_cnt == 0)
			$display("script_text_tokenizer: match");
		else
			$display("script_text_tokenizer: mismatch");
		$finish;
	end

endmodule

@@ script_text_tokenizer.f @@
rtl/core/stt_pkg.sv
rtl/core/stt_front.sv
rtl/core/stt_queue.sv
rtl/core/stt_back.sv
rtl/core/script_text_tokenizer.sv
rtl/core/stt_checker.sv
sim/script_text_tokenizer_tb.sv
